// File: hw/rtl/palette_pixel_scaler_scanline_top_assert.svh
// Assertion macros shared by the palette pixel scaler RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PALETTE_PIXEL_SCALER_SCANLINE_TOP_ASSERT_SVH
`define PALETTE_PIXEL_SCALER_SCANLINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ppss_pkg.sv
// Shared types and constants of the palette pixel scaler.
// No dependencies; used by every module of the block.
package ppss_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int COLOR_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT     = 2'd1;

  // Scale mode codes; anything else behaves as native.
  localparam logic [2:0] MODE_NATIVE = 3'd0;
  localparam logic [2:0] MODE_ASPECT = 3'd1;
  localparam logic [2:0] MODE_PLAIN  = 3'd2;
  localparam logic [2:0] MODE_CRT    = 3'd3;
  localparam logic [2:0] MODE_GRID   = 3'd4;

  // Input word function codes.
  localparam logic FUNC_PAL_WRITE = 1'b0;
  localparam logic FUNC_PIXEL     = 1'b1;

  // Aspect phase values of interest.
  localparam logic [2:0] PHASE_REPEAT = 3'd3;
  localparam logic [2:0] PHASE_AFTER  = 3'd4;
  localparam logic [2:0] PHASE_LAST   = 3'd5;

  // How one pixel expands into output words.
  typedef struct packed {
    logic [1:0] n_last;  // index of the final output word
    logic [3:0] dmask;   // bit k set: output word k is darkened
  } emit_ctl_t;

endpackage

// File: hw/rtl/ppss_palette.sv
// Palette memory with per-entry valid bits so that unwritten entries read as zero.
// Depends on ppss_pkg.
module ppss_palette #(
  parameter int PALETTE_ENTRIES = ppss_pkg::PALETTE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(PALETTE_ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [ppss_pkg::COLOR_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic                        rd_hit,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [ppss_pkg::COLOR_W-1:0] rd_data
);

  logic [ppss_pkg::COLOR_W-1:0] mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0]   valid_r;
  logic [ppss_pkg::COLOR_W-1:0] q_r;
  logic                         q_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      q_ok_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_ok_r <= rd_hit && valid_r[rd_addr];
      end
    end
  end

  assign rd_data = q_ok_r ? q_r : '0;

endmodule

// File: hw/rtl/ppss_darken.sv
// Scanline darkening of an RGB565 colour: two-thirds or about three-quarters.
// Depends on ppss_pkg.
module ppss_darken (
  input  logic                         bright,
  input  logic [ppss_pkg::COLOR_W-1:0] color,
  output logic [ppss_pkg::COLOR_W-1:0] dark
);

  // floor(2v/3) for v below 64, by multiplying with 171/512.
  function automatic logic [5:0] two_thirds(input logic [5:0] v);
    logic [14:0] p;
    p = 15'({v, 1'b0}) * 15'd171;
    return p[14:9];
  endfunction

  logic [5:0]  r_d, g_d, b_d;
  logic [15:0] half, quarter, fix, dark_tt, dark_tq;

  always_comb begin
    r_d = two_thirds({1'b0, color[15:11]});
    g_d = two_thirds(color[10:5]);
    b_d = two_thirds({1'b0, color[4:0]});
    dark_tt = {r_d[4:0], g_d, b_d[4:0]};

    half    = (color >> 1) & 16'h7BEF;
    quarter = (color >> 2) & 16'h39E7;
    fix     = ((((color & 16'h0821) << 1) + (color & 16'h1863)) >> 2) & 16'h39E7;
    dark_tq = half + quarter + fix;

    dark = bright ? dark_tq : dark_tt;
  end

endmodule

// File: hw/rtl/ppss_emit.sv
// Output sequencer: holds one expanded pixel and the output register, one word
// a cycle while out_ready is high. Depends on ppss_pkg and the assertion macro header.
`include "palette_pixel_scaler_scanline_top_assert.svh"

module ppss_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s_valid,
  output logic                         s_load,
  input  logic [ppss_pkg::COLOR_W-1:0] s_color,
  input  logic [ppss_pkg::COLOR_W-1:0] s_dark,
  input  ppss_pkg::emit_ctl_t          s_ctl,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ppss_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                         out_sub_row,
  output logic                         out_sub_col,
  output logic                         out_last_of_run
);

  logic                         em_valid_r;
  logic [1:0]                   em_cnt_r;
  ppss_pkg::emit_ctl_t          em_ctl_r;
  logic [ppss_pkg::COLOR_W-1:0] em_color_r, em_dark_r;

  logic                         out_valid_r, out_row_r, out_col_r, out_last_r;
  logic [ppss_pkg::COLOR_W-1:0] out_color_r;

  logic out_free, em_fire, em_take;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    em_fire  = em_valid_r && out_free;
    em_take  = em_fire && (em_cnt_r == em_ctl_r.n_last);
    s_load   = s_valid && (!em_valid_r || em_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r  <= 1'b0;
      em_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s_load) begin
        em_valid_r <= 1'b1;
        em_cnt_r   <= '0;
      end else if (em_take) begin
        em_valid_r <= 1'b0;
      end else if (em_fire) begin
        em_cnt_r <= em_cnt_r + 2'd1;
      end
      if (em_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      em_ctl_r   <= s_ctl;
      em_color_r <= s_color;
      em_dark_r  <= s_dark;
    end
    if (em_fire) begin
      out_color_r <= em_ctl_r.dmask[em_cnt_r] ? em_dark_r : em_color_r;
      out_row_r   <= em_cnt_r[1];
      out_col_r   <= em_cnt_r[0];
      out_last_r  <= em_take;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;
  assign out_sub_row     = out_row_r;
  assign out_sub_col     = out_col_r;
  assign out_last_of_run = out_last_r;

  `PPSS_ASSERT_SAME(a_cnt_in_run, em_valid_r, em_cnt_r <= em_ctl_r.n_last, "word count past run")
  `PPSS_ASSERT_NEXT(a_last_marked, em_take, out_valid_r && out_last_r, "run end not marked")

endmodule

// File: hw/rtl/palette_pixel_scaler_scanline_top.sv
// Palette lookup and 2x pixel scaler with scanline darkening, RGB565 out.
// Top level; depends on ppss_pkg, ppss_palette, ppss_darken, ppss_emit and
// the assertion macro header.
//
// Usage: the input channel carries one word per palette write (func 0) or per
// indexed pixel (func 1). A palette write packs 8-bit red, green and blue to
// RGB565 and stores it; it produces no output word. A pixel is looked up and
// expanded into one output word (native), one or two (aspect 7/6, the fourth
// of every six repeated) or four (the x2 modes, upper row first, left first).
// The configuration channel is always ready; write it only while idle.
// Pipeline: a pixel's palette read is registered at its accept edge, then
// the pixel moves through the expansion register and the output register.
// Throughput: one input word per cycle while each pixel makes one output word
// and the receiver is ready; the x2 modes are held back by the single output
// port draining one word a cycle. Palette writes are taken one per cycle
// while no pixel held in the read stage blocks the input.
// Reset clears the palette to black through per-entry valid bits, the aspect
// phase and both configuration registers; no clearing pass is needed.
// When the receiver stalls, the output word holds, the expansion register
// and the read stage fill, and then in_ready drops until space frees up.
`include "palette_pixel_scaler_scanline_top_assert.svh"

module palette_pixel_scaler_scanline_top #(
  parameter int PALETTE_ENTRIES = ppss_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppss_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [7:0]                        in_color_index,
  input  logic [7:0]                        in_red_in,
  input  logic [7:0]                        in_green_in,
  input  logic [7:0]                        in_blue_in,
  input  logic                              in_line_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ppss_pkg::COLOR_W-1:0]      out_pixel_color,
  output logic                              out_sub_row,
  output logic                              out_sub_col,
  output logic                              out_last_of_run
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  // Configuration registers.
  logic [2:0] scale_mode_r;
  logic       bright_r;

  // Aspect phase counter.
  logic [2:0] phase_r, phase_nxt, phase_eff;

  // Read stage: the pixel whose palette read is in flight or held.
  logic                s1_valid_r;
  ppss_pkg::emit_ctl_t s1_ctl_r, s1_ctl_nxt;

  logic in_acc, pix_acc, wr_acc, in_range, em_load;
  logic [ppss_pkg::COLOR_W-1:0] rd_color, dark_color, wr_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r <= ppss_pkg::MODE_NATIVE;
      bright_r     <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == ppss_pkg::REG_SCALE_MODE) begin
        scale_mode_r <= cfg_data[2:0];
      end else if (cfg_index == ppss_pkg::REG_BRIGHT) begin
        bright_r <= cfg_data[0];
      end
    end
  end

  // The read stage only frees up when the sequencer takes its pixel.
  assign in_ready = !s1_valid_r || em_load;

  always_comb begin
    in_acc   = in_valid && in_ready;
    pix_acc  = in_acc && (in_func == ppss_pkg::FUNC_PIXEL);
    in_range = {1'b0, in_color_index} < 9'(PALETTE_ENTRIES);
    wr_acc   = in_acc && (in_func == ppss_pkg::FUNC_PAL_WRITE) && in_range;
    wr_color = {in_red_in[7:3], in_green_in[7:2], in_blue_in[7:3]};

    // A line start rewinds the phase before the pixel is handled, in any mode.
    phase_eff  = in_line_start ? 3'd0 : phase_r;
    phase_nxt  = phase_eff;
    s1_ctl_nxt = '{n_last: 2'd0, dmask: 4'b0000};
    case (scale_mode_r)
      ppss_pkg::MODE_ASPECT: begin
        if (phase_eff == ppss_pkg::PHASE_REPEAT) begin
          s1_ctl_nxt.n_last = 2'd1;
          phase_nxt = ppss_pkg::PHASE_AFTER;
        end else if (phase_eff >= ppss_pkg::PHASE_LAST) begin
          phase_nxt = 3'd0;
        end else begin
          phase_nxt = phase_eff + 3'd1;
        end
      end
      ppss_pkg::MODE_PLAIN: begin
        s1_ctl_nxt = '{n_last: 2'd3, dmask: 4'b0000};
      end
      ppss_pkg::MODE_CRT: begin
        s1_ctl_nxt = '{n_last: 2'd3, dmask: 4'b1100};
      end
      ppss_pkg::MODE_GRID: begin
        s1_ctl_nxt = '{n_last: 2'd3, dmask: 4'b1110};
      end
      default: begin
        s1_ctl_nxt = '{n_last: 2'd0, dmask: 4'b0000};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (pix_acc) begin
        phase_r    <= phase_nxt;
        s1_valid_r <= 1'b1;
      end else if (em_load) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // A write lands at its accept edge; a later pixel reads at a later edge,
  // so reads always see earlier writes and no forwarding is needed.
  ppss_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_acc),
    .wr_addr (in_color_index[IDX_W-1:0]),
    .wr_data (wr_color),
    .rd_en   (pix_acc),
    .rd_hit  (in_range),
    .rd_addr (in_color_index[IDX_W-1:0]),
    .rd_data (rd_color)
  );

  ppss_darken u_darken (
    .bright (bright_r),
    .color  (rd_color),
    .dark   (dark_color)
  );

  ppss_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .s_valid         (s1_valid_r),
    .s_load          (em_load),
    .s_color         (rd_color),
    .s_dark          (dark_color),
    .s_ctl           (s1_ctl_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color),
    .out_sub_row     (out_sub_row),
    .out_sub_col     (out_sub_col),
    .out_last_of_run (out_last_of_run)
  );

  `PPSS_ASSERT_NEXT(a_s1_held, s1_valid_r && !em_load, s1_valid_r, "read stage pixel dropped")
  `PPSS_ASSERT_SAME(a_no_rw_clash, wr_acc, !pix_acc, "palette write and read in one cycle")

endmodule

// File: tb/tb_palette_pixel_scaler_scanline_top.sv
// Self-checking testbench for the palette pixel scaler with scanline darkening.
// Depends on ppss_pkg and palette_pixel_scaler_scanline_top; predicts every
// output word from its own copy of the palette, aspect phase and registers.

module tb_palette_pixel_scaler_scanline_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The scale mode register is three bits wide; the top three codes are
  // unassigned and must behave as native.
  localparam logic [2:0] MODE_RESERVED_A = 3'd5;
  localparam logic [2:0] MODE_RESERVED_B = 3'd6;
  localparam logic [2:0] MODE_RESERVED_C = 3'd7;

  // Cycles left after the last expected word before the registers are touched.
  // Palette writes make no output word, so one may still be in flight; this
  // leaves a margin for it to land.
  localparam int DRAIN_CYCLES = 8;
  // Cycles without any handshake on any channel before the run is abandoned.
  localparam int QUIET_LIMIT  = 2000;
  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int LONG_HOLD    = 300;

  // One input word as presented on the in_ channel.
  typedef struct packed {
    logic       func;
    logic [7:0] color_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       line_start;
  } scaler_word_t;

  // One output word as expected on the out_ channel.
  typedef struct packed {
    logic [15:0] color;
    logic        row;
    logic        col;
    logic        last;
  } subpixel_t;

  // Every input starts at a known value so the block never sees X.
  logic                            clk            = 1'b0;
  logic                            rst_n          = 1'b0;
  logic                            cfg_valid      = 1'b0;
  logic                            cfg_ready;
  logic [ppss_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [ppss_pkg::CFG_DATA_W-1:0] cfg_data       = '0;
  logic                            in_valid       = 1'b0;
  logic                            in_ready;
  logic                            in_func        = ppss_pkg::FUNC_PAL_WRITE;
  logic [7:0]                      in_color_index = '0;
  logic [7:0]                      in_red_in      = '0;
  logic [7:0]                      in_green_in    = '0;
  logic [7:0]                      in_blue_in     = '0;
  logic                            in_line_start  = 1'b0;
  logic                            out_valid;
  logic                            out_ready      = 1'b0;
  logic [ppss_pkg::COLOR_W-1:0]    out_pixel_color;
  logic                            out_sub_row;
  logic                            out_sub_col;
  logic                            out_last_of_run;

  // Words waiting to be offered, and output words still owed by the block.
  scaler_word_t pending_words[$];
  subpixel_t    expected_subpixels[$];
  // Palette entries written so far; pixels mostly pick from these so that
  // the colours seen on the output are not all black.
  logic [7:0]   written_entries[$];

  // Our own copy of the block's state and registers.
  logic [15:0]  shadow_palette [256];
  logic [2:0]   shadow_phase;
  logic [2:0]   shadow_mode;
  logic         shadow_bright;

  int unsigned  words_queued   = 0;
  int unsigned  words_accepted = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  recv_stall_pct  = 0;
  int unsigned  hold_left       = 0;
  bit           long_hold_pending = 1'b0;
  scaler_word_t word_on_bus;

  palette_pixel_scaler_scanline_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_color_index  (in_color_index),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .in_line_start   (in_line_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color),
    .out_sub_row     (out_sub_row),
    .out_sub_col     (out_sub_col),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Scanline darkening, two-thirds flavour: each channel is widened to eight
  // bits, multiplied by 2/3 with truncation and cut back to its 565 width.
  function automatic logic [15:0] dim_two_thirds(input logic [15:0] c);
    logic [31:0] rd, gd, bd;
    rd = ({24'd0, c[15:11], 3'b000} * 2) / 3;
    gd = ({24'd0, c[10:5], 2'b00} * 2) / 3;
    bd = ({24'd0, c[4:0], 3'b000} * 2) / 3;
    return {rd[7:3], gd[7:2], bd[7:3]};
  endfunction

  // Bright darkening: half plus quarter of each channel, with the bits lost
  // by the shifts added back in, all within the 565 lane masks.
  function automatic logic [15:0] dim_three_quarters(input logic [15:0] c);
    logic [31:0] wide, half, quarter, fix;
    wide    = {16'd0, c};
    half    = (wide >> 1) & 32'h7BEF;
    quarter = (wide >> 2) & 32'h39E7;
    fix     = ((((wide & 32'h0821) << 1) + (wide & 32'h1863)) >> 2) & 32'h39E7;
    return 16'(half + quarter + fix);
  endfunction

  function automatic void owe_subpixel(input logic [15:0] color, input logic row,
                                       input logic col, input logic last);
    subpixel_t s;
    s.color = color;
    s.row   = row;
    s.col   = col;
    s.last  = last;
    expected_subpixels.push_back(s);
  endfunction

  // Works out what one accepted input word does to the state and which
  // output words it must cause, in order.
  function automatic void expand_word(input scaler_word_t w);
    logic [15:0] base, dim;
    if (w.func == ppss_pkg::FUNC_PAL_WRITE) begin
      // Top five, six and five bits of red, green and blue; no output word.
      shadow_palette[w.color_index] = {w.red_in[7:3], w.green_in[7:2], w.blue_in[7:3]};
      return;
    end
    // A line start clears the aspect phase whatever the mode is.
    if (w.line_start)
      shadow_phase = '0;
    base = shadow_palette[w.color_index];
    dim  = shadow_bright ? dim_three_quarters(base) : dim_two_thirds(base);
    case (shadow_mode)
      ppss_pkg::MODE_ASPECT: begin
        if (shadow_phase == ppss_pkg::PHASE_REPEAT) begin
          owe_subpixel(base, 1'b0, 1'b0, 1'b0);
          owe_subpixel(base, 1'b0, 1'b1, 1'b1);
          shadow_phase = ppss_pkg::PHASE_AFTER;
        end else begin
          owe_subpixel(base, 1'b0, 1'b0, 1'b1);
          shadow_phase = (shadow_phase >= ppss_pkg::PHASE_LAST) ? 3'd0
                                                                : shadow_phase + 3'd1;
        end
      end
      ppss_pkg::MODE_PLAIN: begin
        owe_subpixel(base, 1'b0, 1'b0, 1'b0);
        owe_subpixel(base, 1'b0, 1'b1, 1'b0);
        owe_subpixel(base, 1'b1, 1'b0, 1'b0);
        owe_subpixel(base, 1'b1, 1'b1, 1'b1);
      end
      ppss_pkg::MODE_CRT: begin
        owe_subpixel(base, 1'b0, 1'b0, 1'b0);
        owe_subpixel(base, 1'b0, 1'b1, 1'b0);
        owe_subpixel(dim,  1'b1, 1'b0, 1'b0);
        owe_subpixel(dim,  1'b1, 1'b1, 1'b1);
      end
      ppss_pkg::MODE_GRID: begin
        owe_subpixel(base, 1'b0, 1'b0, 1'b0);
        owe_subpixel(dim,  1'b0, 1'b1, 1'b0);
        owe_subpixel(dim,  1'b1, 1'b0, 1'b0);
        owe_subpixel(dim,  1'b1, 1'b1, 1'b1);
      end
      default: owe_subpixel(base, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  // Sending side. When the word on the bus is taken it is handed to the
  // predictor, and the next one (if any, and if this cycle is not an idle
  // one) goes straight on the bus. Valid is assigned once per edge only.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expand_word(word_on_bus);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          word_on_bus = pending_words.pop_front();
          in_func        <= word_on_bus.func;
          in_color_index <= word_on_bus.color_index;
          in_red_in      <= word_on_bus.red_in;
          in_green_in    <= word_on_bus.green_in;
          in_blue_in     <= word_on_bus.blue_in;
          in_line_start  <= word_on_bus.line_start;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiving side. Every accepted word is compared field by field with the
  // oldest one owed. Ready is random except during a requested long hold,
  // which is timed here so that the sender keeps pushing meanwhile.
  always @(posedge clk) begin : receive_side
    subpixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_subpixels.size() == 0) begin
          $error("output word 0x%04h arrived with nothing expected", out_pixel_color);
          mismatch_count++;
        end else begin
          want = expected_subpixels.pop_front();
          if (out_pixel_color !== want.color) begin
            $error("pixel_color: expected 0x%04h, got 0x%04h", want.color, out_pixel_color);
            mismatch_count++;
          end
          if (out_sub_row !== want.row) begin
            $error("sub_row: expected %0d, got %0d", want.row, out_sub_row);
            mismatch_count++;
          end
          if (out_sub_col !== want.col) begin
            $error("sub_col: expected %0d, got %0d", want.col, out_sub_col);
            mismatch_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
            mismatch_count++;
          end
        end
      end
      if (long_hold_pending) begin
        hold_left = LONG_HOLD;
        long_hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no handshake at
  // all, including the case of a word that the block never produces.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void queue_palette_write(input logic [7:0] idx, input logic [7:0] red,
                                              input logic [7:0] green, input logic [7:0] blue,
                                              input logic ls);
    scaler_word_t w;
    w.func        = ppss_pkg::FUNC_PAL_WRITE;
    w.color_index = idx;
    w.red_in      = red;
    w.green_in    = green;
    w.blue_in     = blue;
    w.line_start  = ls;
    pending_words.push_back(w);
    written_entries.push_back(idx);
    words_queued++;
  endfunction

  // Colour fields of a pixel word carry noise; the block must ignore them.
  function automatic void queue_pixel(input logic [7:0] idx, input logic ls);
    scaler_word_t w;
    w.func        = ppss_pkg::FUNC_PIXEL;
    w.color_index = idx;
    w.red_in      = 8'($urandom_range(0, 255));
    w.green_in    = 8'($urandom_range(0, 255));
    w.blue_in     = 8'($urandom_range(0, 255));
    w.line_start  = ls;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // Waits until every queued word has been taken and every owed output word
  // has arrived, then gives a possible trailing palette write time to land.
  task automatic wait_until_idle();
    while (words_accepted != words_queued || expected_subpixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it once all writes are done so
  // that back-to-back writes never assign it twice in one edge.
  task automatic write_register(input logic [ppss_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ppss_pkg::CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ppss_pkg::REG_SCALE_MODE)
      shadow_mode = value;
    else if (idx == ppss_pkg::REG_BRIGHT)
      shadow_bright = value[0];
  endtask

  task automatic set_scaling(input logic [2:0] mode, input logic bright);
    wait_until_idle();
    write_register(ppss_pkg::REG_SCALE_MODE, mode);
    write_register(ppss_pkg::REG_BRIGHT, {{(ppss_pkg::CFG_DATA_W-1){1'b0}}, bright});
    cfg_valid <= 1'b0;
  endtask

  // One random stretch under a given setting and idling pattern. Roughly a
  // third of the words are palette writes; pixels favour written entries and
  // now and then start a new line, so aspect groups run through all phases
  // and are also cut short at random points.
  task automatic random_stretch(input logic [2:0] mode, input logic bright,
                                input int unsigned send_idle, input int unsigned recv_stall,
                                input bit squeeze, input int n);
    logic [7:0] idx;
    set_scaling(mode, bright);
    sender_idle_pct = send_idle;
    recv_stall_pct  = recv_stall;
    if (squeeze)
      long_hold_pending = 1'b1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        queue_palette_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
      end else begin
        if (written_entries.size() > 0 && $urandom_range(0, 99) < 75)
          idx = written_entries[$urandom_range(0, written_entries.size() - 1)];
        else
          idx = 8'($urandom_range(0, 255));
        queue_pixel(idx, ($urandom_range(0, 99) < 10));
      end
    end
    wait_until_idle();
  endtask

  // Main sequence: reset, a directed pass over every mode and corner, then
  // eleven random stretches under changing registers and idling patterns.
  initial begin
    foreach (shadow_palette[i])
      shadow_palette[i] = '0;
    shadow_phase  = '0;
    shadow_mode   = ppss_pkg::MODE_NATIVE;
    shadow_bright = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Palette extremes: full white at the top entry, pure primaries, low bits
    // that the packing must drop, and a write carrying a stray line start.
    queue_palette_write(8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_palette_write(8'd1,   8'hFF, 8'h00, 8'h00, 1'b0);
    queue_palette_write(8'd2,   8'h00, 8'hFF, 8'h00, 1'b0);
    queue_palette_write(8'd3,   8'h00, 8'h00, 8'hFF, 1'b1);
    queue_palette_write(8'd4,   8'h07, 8'h03, 8'h07, 1'b0);
    queue_palette_write(8'd128, 8'hA5, 8'h5A, 8'hC3, 1'b0);
    queue_palette_write(8'd0,   8'h00, 8'h00, 8'h00, 1'b0);

    // Native after reset, including an entry that reads back as black.
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0,   1'b1);
    queue_pixel(8'd1,   1'b0);

    // Aspect: a full group of six with the fourth pixel repeated, the wrap
    // back to phase zero, and a line start that cuts a group short.
    set_scaling(ppss_pkg::MODE_ASPECT, 1'b0);
    queue_pixel(8'd1,   1'b1);
    queue_pixel(8'd2,   1'b0);
    queue_pixel(8'd3,   1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd4,   1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(8'd1,   1'b0);
    queue_pixel(8'd2,   1'b0);
    queue_pixel(8'd255, 1'b1);

    // Both scanline flavours, one on each darkening strength, plain doubling,
    // and an unassigned mode code that must fall back to native.
    set_scaling(ppss_pkg::MODE_CRT, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd128, 1'b0);
    set_scaling(ppss_pkg::MODE_GRID, 1'b1);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd4,   1'b0);
    queue_pixel(8'd128, 1'b0);
    set_scaling(ppss_pkg::MODE_PLAIN, 1'b1);
    queue_pixel(8'd2, 1'b0);
    set_scaling(MODE_RESERVED_C, 1'b0);
    queue_pixel(8'd3, 1'b0);

    // Random stretches. The first one holds the receiver off for a long
    // while with the sender at full rate, so the block must back-pressure.
    random_stretch(ppss_pkg::MODE_CRT,    1'b0,  0,  0, 1'b1, 20);
    random_stretch(ppss_pkg::MODE_ASPECT, 1'b1, 58,  0, 1'b0, 20);
    random_stretch(ppss_pkg::MODE_GRID,   1'b1,  0, 58, 1'b0, 20);
    random_stretch(ppss_pkg::MODE_PLAIN,  1'b0, 26, 26, 1'b0, 20);
    random_stretch(MODE_RESERVED_C,       1'b1,  0,  0, 1'b0, 20);
    random_stretch(ppss_pkg::MODE_NATIVE, 1'b0, 58,  0, 1'b0, 20);
    random_stretch(MODE_RESERVED_A,       1'b0,  0, 58, 1'b0, 20);
    random_stretch(ppss_pkg::MODE_ASPECT, 1'b1, 26, 26, 1'b0, 20);
    random_stretch(ppss_pkg::MODE_CRT,    1'b1,  0,  0, 1'b0, 20);
    random_stretch(MODE_RESERVED_B,       1'b0, 58,  0, 1'b0, 10);
    random_stretch(ppss_pkg::MODE_GRID,   1'b0, 26, 26, 1'b0, 12);

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
